// ===== sv/sfd_pkg.sv =====
// Shared types, constants and saturation helper for the stereo feedback delay.
package sfd_pkg;

   localparam int SAMPLE_W      = 24;
   localparam int SAT_IN_W      = 28;
   localparam int DEPTH_DEFAULT = 131072;
   localparam int DELAY_W       = 33;
   localparam int COEF_W        = 16;
   localparam int MIX_W         = 17;
   localparam int CSR_AW        = 6;
   localparam int CSR_DW        = 64;

   localparam logic [COEF_W-1:0]  FEEDBACK_MAX = 16'd62259;
   localparam logic [MIX_W-1:0]   MIX_MAX      = 17'd65536;

   localparam logic [DELAY_W-1:0] TARGET_RESET  = 33'd31457280;
   localparam logic [COEF_W-1:0]  SMOOTH_RESET  = 16'd170;
   localparam logic [COEF_W-1:0]  GAIN_RESET    = 16'd32768;
   localparam logic [MIX_W-1:0]   MIX_RESET     = 17'd32768;
   localparam logic               PING_RESET    = 1'b0;
   localparam logic [COEF_W-1:0]  LOWPASS_RESET = 16'd65535;
   localparam logic [COEF_W-1:0]  HIGHPASS_RESET = 16'd0;

   typedef enum logic [2:0] {
      REG_TARGET_DELAY,
      REG_SMOOTH_FACTOR,
      REG_FEEDBACK_GAIN,
      REG_MIX_AMOUNT,
      REG_PING_PONG,
      REG_LOWPASS_COEFF,
      REG_HIGHPASS_COEFF
   } csr_reg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_in;
      logic signed [SAMPLE_W-1:0] right_in;
   } req_data_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } rsp_data_type;

   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [SAT_IN_W-1:0] v);
      logic signed [SAT_IN_W-1:0] hi;
      logic signed [SAT_IN_W-1:0] lo;
      hi = {{(SAT_IN_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return SAMPLE_W'(hi);
      end else if (v < lo) begin
         return SAMPLE_W'(lo);
      end
      return SAMPLE_W'(v);
   endfunction

endpackage

// ===== sv/stereo_feedback_delay.sv =====
// Stereo feedback delay: microcoded sequencer over one shared multiplier and two ring lines.
//
// Input beats (req_valid/req_ready) carry one stereo dry pair; each gives exactly one
// mixed pair on the result channel (rsp_valid/rsp_ready). Configuration is written
// through the csr_ APB port, 64-bit registers at 8-byte spacing; the user must write it
// only while idle, which the block itself does not enforce. An 18-entry program in a
// control ROM runs each beat, its channel steps once per channel, 26 steps in all; every
// product goes through a single 26x18 multiplier, one per step, which sets the pace.
// rsp_valid rises once the final step has registered the result, and a new beat is taken
// only after the previous one has run the whole program.
// req_ready is high only in the program's first step. A finished result waits in an
// output register, and the next beat is accepted and processed meanwhile; only the
// final step stalls if that register is still full.
// Reset (synchronous) restores register defaults, clears filter state, the write
// pointer and the fill count. Ring entries not yet written since reset read as zero
// through the fill count, so no clearing pass is needed.
module stereo_feedback_delay #(
   parameter int DEPTH = sfd_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  sfd_pkg::req_data_type        req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output sfd_pkg::rsp_data_type        rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [sfd_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [sfd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [sfd_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int SW = sfd_pkg::SAMPLE_W;
   localparam int PW = 44;

   typedef enum logic [1:0] {A_SRC, A_DIFF, A_MAG_HI, A_MAG_LO} a_sel_type;
   typedef enum logic [2:0] {B_SMOOTH, B_GAIN, B_MIX, B_LPC, B_HPC} b_sel_type;
   typedef enum logic [3:0] {
      OP_NOP, OP_ACCEPT, OP_MAG, OP_ACC_HI, OP_ACC_LO, OP_SMOOTH, OP_CLAMP, OP_RADDR,
      OP_DLYDIFF, OP_FBSUM, OP_OUT_LPDIFF, OP_LP, OP_HPDIFF_WRITE, OP_HP, OP_PUBLISH
   } op_type;
   typedef enum logic [1:0] {HOLD_NONE, HOLD_REQ, HOLD_RSP} hold_type;
   typedef enum logic [1:0] {BR_NONE, BR_FIRST_CH, BR_ALWAYS} br_type;

   typedef struct packed {
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      op_type     op;
      hold_type   hold;
      br_type     br;
      logic [4:0] target;
   } ucode_type;

   localparam logic [4:0] STEP_IDLE     = 5'd0;
   localparam logic [4:0] STEP_CH_START = 5'd9;

   function automatic ucode_type ucode_rom(input logic [4:0] pc);
      ucode_type w;
      w = '{a_sel: A_SRC, b_sel: B_GAIN, op: OP_NOP, hold: HOLD_NONE, br: BR_NONE,
            target: STEP_IDLE};
      case (pc)
         5'd0: begin
            w.op = OP_ACCEPT; w.hold = HOLD_REQ;
         end
         5'd1: begin
            w.op = OP_MAG;
         end
         5'd2: begin
            w.a_sel = A_MAG_HI; w.b_sel = B_SMOOTH;
         end
         5'd3: begin
            w.a_sel = A_MAG_LO; w.b_sel = B_SMOOTH; w.op = OP_ACC_HI;
         end
         5'd4: begin
            w.op = OP_ACC_LO;
         end
         5'd5: begin
            w.op = OP_SMOOTH;
         end
         5'd6: begin
            w.op = OP_CLAMP;
         end
         5'd7: begin
            w.op = OP_RADDR;
         end
         5'd8: begin
            w.op = OP_NOP;
         end
         5'd9: begin
            w.a_sel = A_SRC; w.b_sel = B_GAIN; w.op = OP_DLYDIFF;
         end
         5'd10: begin
            w.a_sel = A_DIFF; w.b_sel = B_MIX; w.op = OP_FBSUM;
         end
         5'd11: begin
            w.op = OP_OUT_LPDIFF;
         end
         5'd12: begin
            w.a_sel = A_DIFF; w.b_sel = B_LPC;
         end
         5'd13: begin
            w.op = OP_LP;
         end
         5'd14: begin
            w.op = OP_HPDIFF_WRITE;
         end
         5'd15: begin
            w.a_sel = A_DIFF; w.b_sel = B_HPC;
         end
         5'd16: begin
            w.op = OP_HP; w.br = BR_FIRST_CH; w.target = STEP_CH_START;
         end
         5'd17: begin
            w.op = OP_PUBLISH; w.hold = HOLD_RSP; w.br = BR_ALWAYS; w.target = STEP_IDLE;
         end
         default: begin
            w.br = BR_ALWAYS; w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   // configuration
   logic [sfd_pkg::DELAY_W-1:0] target_ff;
   logic [sfd_pkg::COEF_W-1:0]  smooth_ff;
   logic [sfd_pkg::COEF_W-1:0]  gain_ff;
   logic [sfd_pkg::MIX_W-1:0]   mix_ff;
   logic                        ping_ff;
   logic [sfd_pkg::COEF_W-1:0]  lpc_ff;
   logic [sfd_pkg::COEF_W-1:0]  hpc_ff;
   logic                        csr_we;
   sfd_pkg::csr_reg_type        csr_idx;

   // sequencer and datapath
   logic [4:0]                  step_ff;
   logic [4:0]                  step_in;
   ucode_type                   ctl;
   logic                        held;
   logic                        br_taken;
   logic                        ch_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   sfd_pkg::rsp_data_type       rsp_ff;
   sfd_pkg::req_data_type       req_ff;
   logic signed [sfd_pkg::DELAY_W:0] diff_ff;
   logic                        neg_ff;
   logic [sfd_pkg::DELAY_W-1:0] mag_ff;
   logic [sfd_pkg::DELAY_W:0]   acc_ff;
   logic [sfd_pkg::DELAY_W-1:0] sm_ff;
   logic [AW-1:0]               d_ff;
   logic [AW-1:0]               wr_ff;
   logic [AW-1:0]               rd_addr_ff;
   logic [FW-1:0]               fill_ff;
   logic signed [SW:0]          t_ff;
   logic signed [SW-1:0]        x_ff;
   logic signed [SW-1:0]        o_ff [2];
   logic signed [SW-1:0]        lp_ff [2];
   logic signed [SW-1:0]        hp_ff [2];
   logic signed [PW-1:0]        prod_ff;

   // ring lines
   logic signed [SW-1:0]        left_mem  [DEPTH];
   logic signed [SW-1:0]        right_mem [DEPTH];
   logic signed [SW-1:0]        rd_l_ff;
   logic signed [SW-1:0]        rd_r_ff;
   logic                        hit_ff;

   logic [sfd_pkg::COEF_W-1:0]  gain_eff;
   logic [sfd_pkg::MIX_W-1:0]   mix_eff;
   logic signed [SW-1:0]        dry_ch;
   logic signed [SW-1:0]        dly_l;
   logic signed [SW-1:0]        dly_r;
   logic signed [SW-1:0]        dly_own;
   logic signed [SW-1:0]        src;
   logic signed [SW-1:0]        lp_cur;
   logic signed [SW-1:0]        hp_cur;
   logic signed [25:0]          mul_a;
   logic signed [17:0]          mul_b;
   logic signed [PW-1:0]        prod_in;
   logic signed [sfd_pkg::SAT_IN_W-1:0] p16;
   logic signed [SW:0]          hf;
   logic signed [SW-1:0]        fb_sample;
   logic [31:0]                 d_wide;
   logic [AW:0]                 raddr_diff;
   logic                        we_l;
   logic                        we_r;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = sfd_pkg::csr_reg_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= sfd_pkg::TARGET_RESET;
         smooth_ff <= sfd_pkg::SMOOTH_RESET;
         gain_ff   <= sfd_pkg::GAIN_RESET;
         mix_ff    <= sfd_pkg::MIX_RESET;
         ping_ff   <= sfd_pkg::PING_RESET;
         lpc_ff    <= sfd_pkg::LOWPASS_RESET;
         hpc_ff    <= sfd_pkg::HIGHPASS_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            sfd_pkg::REG_TARGET_DELAY:   target_ff <= csr_pwdata[sfd_pkg::DELAY_W-1:0];
            sfd_pkg::REG_SMOOTH_FACTOR:  smooth_ff <= csr_pwdata[sfd_pkg::COEF_W-1:0];
            sfd_pkg::REG_FEEDBACK_GAIN:  gain_ff   <= csr_pwdata[sfd_pkg::COEF_W-1:0];
            sfd_pkg::REG_MIX_AMOUNT:     mix_ff    <= csr_pwdata[sfd_pkg::MIX_W-1:0];
            sfd_pkg::REG_PING_PONG:      ping_ff   <= csr_pwdata[0];
            sfd_pkg::REG_LOWPASS_COEFF:  lpc_ff    <= csr_pwdata[sfd_pkg::COEF_W-1:0];
            sfd_pkg::REG_HIGHPASS_COEFF: hpc_ff    <= csr_pwdata[sfd_pkg::COEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         sfd_pkg::REG_TARGET_DELAY:   csr_prdata = sfd_pkg::CSR_DW'(target_ff);
         sfd_pkg::REG_SMOOTH_FACTOR:  csr_prdata = sfd_pkg::CSR_DW'(smooth_ff);
         sfd_pkg::REG_FEEDBACK_GAIN:  csr_prdata = sfd_pkg::CSR_DW'(gain_ff);
         sfd_pkg::REG_MIX_AMOUNT:     csr_prdata = sfd_pkg::CSR_DW'(mix_ff);
         sfd_pkg::REG_PING_PONG:      csr_prdata = sfd_pkg::CSR_DW'(ping_ff);
         sfd_pkg::REG_LOWPASS_COEFF:  csr_prdata = sfd_pkg::CSR_DW'(lpc_ff);
         sfd_pkg::REG_HIGHPASS_COEFF: csr_prdata = sfd_pkg::CSR_DW'(hpc_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // control
   assign ctl       = ucode_rom(step_ff);
   assign req_ready = (ctl.hold == HOLD_REQ);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      case (ctl.hold)
         HOLD_REQ: held = !req_valid;
         HOLD_RSP: held = rsp_valid_ff && !rsp_ready;
         default:  held = 1'b0;
      endcase
      case (ctl.br)
         BR_FIRST_CH: br_taken = !ch_ff;
         BR_ALWAYS:   br_taken = 1'b1;
         default:     br_taken = 1'b0;
      endcase
      if (held) begin
         step_in = step_ff;
      end else if (br_taken) begin
         step_in = ctl.target;
      end else begin
         step_in = step_ff + 5'd1;
      end
      if (!held && ctl.op == OP_PUBLISH) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // operand selection
   always_comb begin
      gain_eff = (gain_ff > sfd_pkg::FEEDBACK_MAX) ? sfd_pkg::FEEDBACK_MAX : gain_ff;
      mix_eff  = (mix_ff > sfd_pkg::MIX_MAX) ? sfd_pkg::MIX_MAX : mix_ff;
      dry_ch   = ch_ff ? req_ff.right_in : req_ff.left_in;
      dly_l    = hit_ff ? rd_l_ff : '0;
      dly_r    = hit_ff ? rd_r_ff : '0;
      dly_own  = ch_ff ? dly_r : dly_l;
      src      = (ping_ff ^ ch_ff) ? dly_r : dly_l;
      lp_cur   = lp_ff[ch_ff];
      hp_cur   = hp_ff[ch_ff];
      p16      = $signed(prod_ff[PW-1:16]);
      hf       = (SW+1)'(lp_cur) - (SW+1)'(hp_cur);
      fb_sample = sfd_pkg::sat_sample(sfd_pkg::SAT_IN_W'(hf));

      case (ctl.a_sel)
         A_SRC:    mul_a = 26'(src);
         A_DIFF:   mul_a = 26'(t_ff);
         A_MAG_HI: mul_a = {10'b0, mag_ff[32:17]};
         A_MAG_LO: mul_a = {9'b0, mag_ff[16:0]};
         default:  mul_a = '0;
      endcase
      case (ctl.b_sel)
         B_SMOOTH: mul_b = {2'b0, smooth_ff};
         B_GAIN:   mul_b = {2'b0, gain_eff};
         B_MIX:    mul_b = {1'b0, mix_eff};
         B_LPC:    mul_b = {2'b0, lpc_ff};
         B_HPC:    mul_b = {2'b0, hpc_ff};
         default:  mul_b = '0;
      endcase
      prod_in = mul_a * mul_b;

      d_wide = 32'(sm_ff[32:16]);
      if (d_wide == 32'd0) begin
         d_wide = 32'd1;
      end else if (d_wide > 32'(DEPTH - 1)) begin
         d_wide = 32'(DEPTH - 1);
      end
      raddr_diff = {1'b0, wr_ff} - {1'b0, d_ff};

      we_l = !held && ctl.op == OP_HPDIFF_WRITE && !ch_ff;
      we_r = !held && ctl.op == OP_HPDIFF_WRITE && ch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         ch_ff        <= 1'b0;
         sm_ff        <= sfd_pkg::TARGET_RESET;
         wr_ff        <= '0;
         fill_ff      <= '0;
         lp_ff[0]     <= '0;
         lp_ff[1]     <= '0;
         hp_ff[0]     <= '0;
         hp_ff[1]     <= '0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (!held && br_taken && ctl.br == BR_FIRST_CH) begin
            ch_ff <= 1'b1;
         end
         if (!held) begin
            case (ctl.op)
               OP_SMOOTH: begin
                  sm_ff <= neg_ff ? sfd_pkg::DELAY_W'(sm_ff - acc_ff)
                                  : sfd_pkg::DELAY_W'(sm_ff + acc_ff);
               end
               OP_RADDR: begin
                  ch_ff <= 1'b0;
               end
               OP_LP: begin
                  lp_ff[ch_ff] <= sfd_pkg::sat_sample(sfd_pkg::SAT_IN_W'(lp_cur) + p16);
               end
               OP_HP: begin
                  hp_ff[ch_ff] <= sfd_pkg::sat_sample(sfd_pkg::SAT_IN_W'(hp_cur) + p16);
               end
               OP_PUBLISH: begin
                  wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
                  if (fill_ff != FW'(DEPTH)) begin
                     fill_ff <= fill_ff + 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (!held) begin
         case (ctl.op)
            OP_ACCEPT: begin
               req_ff  <= req_data;
               diff_ff <= $signed({1'b0, target_ff}) - $signed({1'b0, sm_ff});
            end
            OP_MAG: begin
               neg_ff <= diff_ff[sfd_pkg::DELAY_W];
               mag_ff <= diff_ff[sfd_pkg::DELAY_W] ? sfd_pkg::DELAY_W'(-diff_ff)
                                                   : diff_ff[sfd_pkg::DELAY_W-1:0];
            end
            OP_ACC_HI: begin
               acc_ff <= {prod_ff[32:0], 1'b0};
            end
            OP_ACC_LO: begin
               acc_ff <= acc_ff + (sfd_pkg::DELAY_W+1)'(prod_ff[32:16]);
            end
            OP_CLAMP: begin
               d_ff <= d_wide[AW-1:0];
            end
            OP_RADDR: begin
               rd_addr_ff <= raddr_diff[AW] ? AW'(raddr_diff + (AW+1)'(DEPTH))
                                            : raddr_diff[AW-1:0];
            end
            OP_DLYDIFF: begin
               t_ff <= (SW+1)'(dly_own) - (SW+1)'(dry_ch);
            end
            OP_FBSUM: begin
               x_ff <= sfd_pkg::sat_sample(sfd_pkg::SAT_IN_W'(dry_ch) + p16);
            end
            OP_OUT_LPDIFF: begin
               o_ff[ch_ff] <= sfd_pkg::sat_sample(sfd_pkg::SAT_IN_W'(dry_ch) + p16);
               t_ff        <= (SW+1)'(x_ff) - (SW+1)'(lp_cur);
            end
            OP_HPDIFF_WRITE: begin
               t_ff <= hf;
            end
            OP_PUBLISH: begin
               rsp_ff <= '{left_out: o_ff[0], right_out: o_ff[1]};
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we_l) begin
         left_mem[wr_ff] <= fb_sample;
      end
      rd_l_ff <= left_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (we_r) begin
         right_mem[wr_ff] <= fb_sample;
      end
      rd_r_ff <= right_mem[rd_addr_ff];
   end

   // entries at or beyond the fill count were never written since reset
   always_ff @(posedge clock) begin
      hit_ff <= FW'(rd_addr_ff) < fill_ff;
   end

endmodule

// ===== sv/sfd_checker.sv =====
// Port-level checks for the stereo feedback delay, bound to the top level.
module sfd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input sfd_pkg::rsp_data_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted on consecutive cycles");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after input beat");

endmodule

bind stereo_feedback_delay sfd_checker u_sfd_checker (.*);
